// ----- sv/nwc_pkg.sv -----
package nwc_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int KERNEL_MAX_DEF = 5;
   localparam int PIXEL_BITS_DEF = 8;

   // field widths of the channels and the register port
   localparam int PIX_IN_W   = 8;
   localparam int ROW_OUT_W  = 12;
   localparam int COL_OUT_W  = 11;
   localparam int FILT_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // geometry arithmetic wide enough for any line count plus carry
   localparam int GEO_W = 16;
   // window size, 1 to 7
   localparam int KSZ_W = 3;
   // weight sum: at most 49 in mean mode, 98 in Gaussian mode
   localparam int DIV_W = 7;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_ROWS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_COLS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

   localparam logic        FILTER_MODE_RST  = 1'b0;
   localparam logic [2:0]  WINDOW_ROWS_RST  = 3'd5;
   localparam logic [2:0]  WINDOW_COLS_RST  = 3'd5;
   localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd2048;
   localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd4096;

   localparam int GAUSS_N = 5;
   localparam logic [3:0] GAUSS_W [GAUSS_N*GAUSS_N] = '{
      4'd1, 4'd2, 4'd3,  4'd2, 4'd1,
      4'd2, 4'd6, 4'd8,  4'd6, 4'd2,
      4'd3, 4'd8, 4'd10, 4'd8, 4'd3,
      4'd2, 4'd6, 4'd8,  4'd6, 4'd2,
      4'd1, 4'd2, 4'd3,  4'd2, 4'd1
   };

   typedef struct packed {
      logic             mode;
      logic [KSZ_W-1:0] u;
      logic [KSZ_W-1:0] v;
      logic [GEO_W-1:0] w;
      logic [GEO_W-1:0] h;
      logic [DIV_W-1:0] div;
   } geo_type;

   typedef struct packed {
      logic                 last;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic [DIV_W-1:0]     div;
   } meta_type;

   function automatic int gauss_size(int kmax);
      return (kmax < GAUSS_N) ? kmax : GAUSS_N;
   endfunction

   // Gaussian weight at window cell (a, b), window anchored bottom-right
   function automatic logic [3:0] gauss_weight(int a, int b, int kmax);
      int g;
      int off;
      int base;
      g    = gauss_size(kmax);
      off  = (GAUSS_N - g) >> 1;
      base = kmax - g;
      if (a < base || b < base) return 4'd0;
      return GAUSS_W[(off + a - base) * GAUSS_N + off + b - base];
   endfunction

   function automatic int gauss_sum(int kmax);
      int s;
      s = 0;
      for (int a = 0; a < kmax; a++) begin
         for (int b = 0; b < kmax; b++) begin
            s = s + int'(gauss_weight(a, b, kmax));
         end
      end
      return s;
   endfunction

endpackage

// ----- sv/nwc_req_if.sv -----
interface nwc_req_if;
   logic                          valid;
   logic                          ready;
   logic [nwc_pkg::PIX_IN_W-1:0]  pixel;
   logic                          frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ----- sv/nwc_rsp_if.sv -----
interface nwc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nwc_pkg::ROW_OUT_W-1:0] center_row;
   logic [nwc_pkg::COL_OUT_W-1:0] center_col;
   logic [nwc_pkg::FILT_W-1:0]    filtered;
   logic                          last;

   modport source (output valid, output center_row, output center_col, output filtered,
                   output last, input ready);
   modport sink   (input valid, input center_row, input center_col, input filtered,
                   input last, output ready);
endinterface

// ----- sv/normalized_window_convolution_unit.sv -----
// Box / Gaussian window filter on a raster pixel stream.
// req_chan carries one pixel per request with frame_start on the first pixel
// of an image; rsp_chan returns one filtered sample per interior centre, with
// its row, column and a last flag on the final interior centre. Border
// centres produce nothing. Both channels use valid/ready.
// csr_* writes the mode, window size and image size; write only while idle.
// The front end takes one pixel per cycle while queue slots remain free. Each
// result goes through a bit-serial divider and then the output register, and
// the divider finishes one result before it pops the next;
// a four-entry queue between the window front end and the divider absorbs
// bursts, and req_chan.ready drops once its slots are spoken for.
// A stalled rsp_chan holds its result, fills the queue, then stops requests.
// Synchronous reset clears the position to row 0, column 0, empties the queue
// and sets registers to mean mode, 5x5 window, 2048x4096 image. Line store
// contents are undefined until written; no clearing pass is made.
module normalized_window_convolution_unit #(
   parameter int MAX_WIDTH  = nwc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = nwc_pkg::MAX_HEIGHT_DEF,
   parameter int KERNEL_MAX = nwc_pkg::KERNEL_MAX_DEF,
   parameter int PIXEL_BITS = nwc_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   nwc_req_if.sink                            req_chan,
   nwc_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [nwc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nwc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int ACC_W = PIXEL_BITS + nwc_pkg::DIV_W;
   localparam int MW    = $bits(nwc_pkg::meta_type);
   localparam logic [nwc_pkg::KSZ_W-1:0] KMAX  = nwc_pkg::KSZ_W'(KERNEL_MAX);
   localparam logic [nwc_pkg::KSZ_W-1:0] GSIZE =
      nwc_pkg::KSZ_W'(nwc_pkg::gauss_size(KERNEL_MAX));
   localparam logic [nwc_pkg::DIV_W-1:0] GSUM =
      nwc_pkg::DIV_W'(nwc_pkg::gauss_sum(KERNEL_MAX));

   logic        filter_mode_ff;
   logic [2:0]  window_rows_ff, window_cols_ff;
   logic [11:0] image_width_ff;
   logic [12:0] image_height_ff;

   nwc_pkg::geo_type geo;
   logic [nwc_pkg::KSZ_W-1:0] u_cl, v_cl;
   logic [nwc_pkg::GEO_W-1:0] w_raw, h_raw;

   logic                          push, pop;
   nwc_pkg::meta_type             push_meta, q_meta;
   logic [ACC_W-1:0]              push_acc, q_acc;
   logic [nwc_pkg::QCNT_W-1:0]    q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= nwc_pkg::FILTER_MODE_RST;
         window_rows_ff  <= nwc_pkg::WINDOW_ROWS_RST;
         window_cols_ff  <= nwc_pkg::WINDOW_COLS_RST;
         image_width_ff  <= nwc_pkg::IMAGE_WIDTH_RST;
         image_height_ff <= nwc_pkg::IMAGE_HEIGHT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            nwc_pkg::REG_FILTER_MODE:  filter_mode_ff  <= csr_write_data[0];
            nwc_pkg::REG_WINDOW_ROWS:  window_rows_ff  <= csr_write_data[2:0];
            nwc_pkg::REG_WINDOW_COLS:  window_cols_ff  <= csr_write_data[2:0];
            nwc_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[11:0];
            nwc_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize saturates
   always_comb begin
      u_cl  = (window_rows_ff == '0) ? nwc_pkg::KSZ_W'(1)
            : (window_rows_ff > KMAX) ? KMAX : window_rows_ff;
      v_cl  = (window_cols_ff == '0) ? nwc_pkg::KSZ_W'(1)
            : (window_cols_ff > KMAX) ? KMAX : window_cols_ff;
      w_raw = nwc_pkg::GEO_W'(image_width_ff);
      h_raw = nwc_pkg::GEO_W'(image_height_ff);
      geo.mode = filter_mode_ff;
      geo.u    = filter_mode_ff ? GSIZE : u_cl;
      geo.v    = filter_mode_ff ? GSIZE : v_cl;
      geo.w    = (w_raw == '0) ? nwc_pkg::GEO_W'(1)
               : (w_raw > nwc_pkg::GEO_W'(MAX_WIDTH)) ? nwc_pkg::GEO_W'(MAX_WIDTH) : w_raw;
      geo.h    = (h_raw == '0) ? nwc_pkg::GEO_W'(1)
               : (h_raw > nwc_pkg::GEO_W'(MAX_HEIGHT)) ? nwc_pkg::GEO_W'(MAX_HEIGHT) : h_raw;
      geo.div  = filter_mode_ff ? GSUM
               : nwc_pkg::DIV_W'(nwc_pkg::DIV_W'(u_cl) * nwc_pkg::DIV_W'(v_cl));
   end

   nwc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .KERNEL_MAX (KERNEL_MAX),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .geo       (geo),
      .q_count   (q_count),
      .push      (push),
      .push_meta (push_meta),
      .push_acc  (push_acc)
   );

   nwc_queue #(
      .DATA_W (MW + ACC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_meta, push_acc}),
      .pop       (pop),
      .pop_data  ({q_meta, q_acc}),
      .count     (q_count)
   );

   nwc_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_count == '0),
      .q_meta   (q_meta),
      .q_acc    (q_acc),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= nwc_pkg::QCNT_W'(nwc_pkg::QDEPTH))
      else $error("result queue overflow");

   a_queue_step: assert property (@(posedge clock) disable iff (reset)
      (q_count != $past(q_count)) |->
         (q_count == $past(q_count) + 1'b1 || q_count + 1'b1 == $past(q_count)))
      else $error("result queue count jumped");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (q_count == nwc_pkg::QCNT_W'(nwc_pkg::QDEPTH)) |-> !req_chan.ready)
      else $error("request taken with no queue slot");
`endif

endmodule

// ----- sv/nwc_front.sv -----
module nwc_front #(
   parameter int MAX_WIDTH  = nwc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = nwc_pkg::MAX_HEIGHT_DEF,
   parameter int KERNEL_MAX = nwc_pkg::KERNEL_MAX_DEF,
   parameter int PIXEL_BITS = nwc_pkg::PIXEL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   nwc_req_if.sink                           req_chan,
   input  nwc_pkg::geo_type                  geo,
   input  logic [nwc_pkg::QCNT_W-1:0]        q_count,
   output logic                              push,
   output nwc_pkg::meta_type                 push_meta,
   output logic [PIXEL_BITS+nwc_pkg::DIV_W-1:0] push_acc
);

   localparam int PB    = PIXEL_BITS;
   localparam int K     = KERNEL_MAX;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int LW    = (K - 1) * PB;
   localparam int ACC_W = PB + nwc_pkg::DIV_W;
   localparam int GW    = nwc_pkg::GEO_W;

   // line store: one word per column holds the K-1 previous lines, newest lowest
   logic [LW-1:0] mem [MAX_WIDTH];

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   logic [GW-1:0] r, c, r1, c1, cr, cc, hu, hv;
   logic          emit, accept;
   logic [PB+nwc_pkg::PIX_IN_W-1:0] pix_ext;
   logic [PB-1:0] pix;
   logic [nwc_pkg::QCNT_W:0] used;
   nwc_pkg::meta_type meta;

   logic              s1_v_ff, s1_emit_ff;
   logic [CW-1:0]     s1_c_ff;
   logic [PB-1:0]     s1_pix_ff;
   nwc_pkg::meta_type s1_meta_ff;
   logic [LW-1:0]     rd_ff;

   logic              byp_v_ff;
   logic [CW-1:0]     byp_addr_ff;
   logic [LW-1:0]     byp_data_ff;

   logic [LW-1:0]     old_word, new_word;
   logic [PB-1:0]     colv [K];
   logic [PB-1:0]     win_ff [K][K];

   logic              s2_v_ff;
   nwc_pkg::meta_type s2_meta_ff;
   logic [ACC_W-1:0]  rsum [K];

   logic              s3_v_ff;
   nwc_pkg::meta_type s3_meta_ff;
   logic [ACC_W-1:0]  rsum_ff [K];

   assign pix_ext = {{PB{1'b0}}, req_chan.pixel};
   assign pix     = pix_ext[PB-1:0];

   // credit check: every request that may still produce a result owns a queue slot
   assign used = {1'b0, q_count} + (nwc_pkg::QCNT_W+1)'(s1_v_ff && s1_emit_ff)
               + (nwc_pkg::QCNT_W+1)'(s2_v_ff) + (nwc_pkg::QCNT_W+1)'(s3_v_ff);
   assign req_chan.ready = used < (nwc_pkg::QCNT_W+1)'(nwc_pkg::QDEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      r = req_chan.frame_start ? '0 : GW'(row_ff);
      c = req_chan.frame_start ? '0 : GW'(col_ff);
      if (c >= geo.w) begin
         c = '0;
         r = r + 1'b1;
      end
      if (r >= geo.h) r = '0;
      r1 = r + 1'b1;
      c1 = c + 1'b1;
      if (c1 >= geo.w) begin
         col_in = '0;
         row_in = (r1 >= geo.h) ? '0 : RW'(r1);
      end else begin
         col_in = CW'(c1);
         row_in = RW'(r);
      end
      hu = GW'(geo.u >> 1);
      hv = GW'(geo.v >> 1);
      cr = r1 - GW'(geo.u) + hu;
      cc = c1 - GW'(geo.v) + hv;
      emit = (r1 >= GW'(geo.u)) && (c1 >= GW'(geo.v))
          && (cr + hu <= geo.h - 1'b1) && (cc + hv <= geo.w - 1'b1);
      meta.last = (cr == geo.h - 1'b1 - hu) && (cc == geo.w - 1'b1 - hv);
      meta.row  = nwc_pkg::ROW_OUT_W'(cr);
      meta.col  = nwc_pkg::COL_OUT_W'(cc);
      meta.div  = geo.div;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit;
         s1_c_ff    <= CW'(c);
         s1_pix_ff  <= pix;
         s1_meta_ff <= meta;
         rd_ff      <= mem[CW'(c)];
      end
      if (s1_v_ff) mem[s1_c_ff] <= new_word;
   end

   // a read issued on the edge of the previous write to the same column misses it
   always_comb begin
      old_word = (byp_v_ff && byp_addr_ff == s1_c_ff) ? byp_data_ff : rd_ff;
      new_word = LW'({old_word, s1_pix_ff});
      colv[K-1] = s1_pix_ff;
      for (int a = 0; a < K - 1; a++) begin
         colv[a] = old_word[(K-2-a)*PB +: PB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_v_ff <= 1'b0;
      end else if (s1_v_ff) begin
         byp_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         byp_addr_ff <= s1_c_ff;
         byp_data_ff <= new_word;
         for (int a = 0; a < K; a++) begin
            for (int b = 0; b < K - 1; b++) begin
               win_ff[a][b] <= win_ff[a][b+1];
            end
            win_ff[a][K-1] <= colv[a];
         end
      end
   end

   always_comb begin
      for (int a = 0; a < K; a++) begin
         rsum[a] = '0;
         for (int b = 0; b < K; b++) begin
            if (geo.mode) begin
               rsum[a] = rsum[a]
                       + ACC_W'(win_ff[a][b]) * ACC_W'(nwc_pkg::gauss_weight(a, b, K));
            end else if (nwc_pkg::KSZ_W'(K - a) <= geo.u
                      && nwc_pkg::KSZ_W'(K - b) <= geo.v) begin
               rsum[a] = rsum[a] + ACC_W'(win_ff[a][b]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff && s1_emit_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_meta_ff <= s1_meta_ff;
      s3_meta_ff <= s2_meta_ff;
      for (int a = 0; a < K; a++) begin
         rsum_ff[a] <= rsum[a];
      end
   end

   always_comb begin
      push_acc = '0;
      for (int a = 0; a < K; a++) begin
         push_acc = push_acc + rsum_ff[a];
      end
   end

   assign push      = s3_v_ff;
   assign push_meta = s3_meta_ff;

endmodule

// ----- sv/nwc_queue.sv -----
module nwc_queue #(
   parameter int DATA_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          pop_data,
   output logic [nwc_pkg::QCNT_W-1:0] count
);

   logic [DATA_W-1:0]          data_ff [nwc_pkg::QDEPTH];
   logic [nwc_pkg::QPTR_W-1:0] head_ff, tail_ff;
   logic [nwc_pkg::QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) tail_ff <= tail_ff + 1'b1;
         if (pop)  head_ff <= head_ff + 1'b1;
         count_ff <= count_ff + nwc_pkg::QCNT_W'(push) - nwc_pkg::QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) data_ff[tail_ff] <= push_data;
   end

   assign pop_data = data_ff[head_ff];
   assign count    = count_ff;

endmodule

// ----- sv/nwc_back.sv -----
module nwc_back #(
   parameter int PIXEL_BITS = nwc_pkg::PIXEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  nwc_pkg::meta_type                     q_meta,
   input  logic [PIXEL_BITS+nwc_pkg::DIV_W-1:0]  q_acc,
   output logic                                  pop,
   nwc_rsp_if.source                             rsp_chan
);

   localparam int PB    = PIXEL_BITS;
   localparam int ACC_W = PB + nwc_pkg::DIV_W;
   localparam int SW    = $clog2(PB + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff;
   logic [SW-1:0]     steps_ff;
   logic [ACC_W-1:0]  rem_ff, dsh_ff;
   logic [PB-1:0]     quo_ff;
   nwc_pkg::meta_type meta_ff;
   logic              ge, load;
   logic [PB+nwc_pkg::FILT_W-1:0] quo_ext;

   logic                          out_v_ff;
   logic [nwc_pkg::ROW_OUT_W-1:0] out_row_ff;
   logic [nwc_pkg::COL_OUT_W-1:0] out_col_ff;
   logic [nwc_pkg::FILT_W-1:0]    out_filt_ff;
   logic                          out_last_ff;

   assign pop     = (state_ff == ST_IDLE) && !q_empty;
   assign ge      = rem_ff >= dsh_ff;
   assign load    = (state_ff == ST_DONE) && (!out_v_ff || rsp_chan.ready);
   assign quo_ext = {{nwc_pkg::FILT_W{1'b0}}, quo_ff};

   // restoring division, one quotient bit per cycle, MSB first
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (pop) state_ff <= ST_RUN;
            ST_RUN:  if (steps_ff == SW'(1)) state_ff <= ST_DONE;
            ST_DONE: if (load) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rem_ff   <= q_acc;
         dsh_ff   <= ACC_W'(q_meta.div) << (PB - 1);
         quo_ff   <= '0;
         steps_ff <= SW'(PB);
         meta_ff  <= q_meta;
      end else if (state_ff == ST_RUN) begin
         rem_ff   <= ge ? rem_ff - dsh_ff : rem_ff;
         dsh_ff   <= dsh_ff >> 1;
         quo_ff   <= PB'({quo_ff, ge});
         steps_ff <= steps_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (load) begin
         out_v_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff  <= meta_ff.row;
         out_col_ff  <= meta_ff.col;
         out_filt_ff <= quo_ext[nwc_pkg::FILT_W-1:0];
         out_last_ff <= meta_ff.last;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.center_row = out_row_ff;
   assign rsp_chan.center_col = out_col_ff;
   assign rsp_chan.filtered   = out_filt_ff;
   assign rsp_chan.last       = out_last_ff;

endmodule

// ----- verif/normalized_window_convolution_unit_tb.sv -----
module normalized_window_convolution_unit_tb;

   typedef struct {
      logic [nwc_pkg::ROW_OUT_W-1:0] row;
      logic [nwc_pkg::COL_OUT_W-1:0] col;
      logic [nwc_pkg::FILT_W-1:0]    filtered;
      logic                          last;
   } filtered_pixel_type;

   class filter_scoreboard;
      logic               mode;
      logic [2:0]         win_rows;
      logic [2:0]         win_cols;
      logic [11:0]        img_width;
      logic [12:0]        img_height;
      int                 line_mem[4*nwc_pkg::MAX_WIDTH_DEF];
      int                 window[25];
      int                 row_pos;
      int                 col_pos;
      filtered_pixel_type pending[$];
      int                 errors;
      int                 results_seen;

      function new();
         mode = nwc_pkg::FILTER_MODE_RST;
         win_rows = nwc_pkg::WINDOW_ROWS_RST;
         win_cols = nwc_pkg::WINDOW_COLS_RST;
         img_width = nwc_pkg::IMAGE_WIDTH_RST;
         img_height = nwc_pkg::IMAGE_HEIGHT_RST;
         foreach (line_mem[k]) line_mem[k] = 0;
         foreach (window[k]) window[k] = 0;
         row_pos = 0;
         col_pos = 0;
         errors = 0;
         results_seen = 0;
      endfunction

      function int clip(int x, int hi);
         if (x < 1) return 1;
         if (x > hi) return hi;
         return x;
      endfunction

      function void write_reg(logic [nwc_pkg::CSR_IDX_W-1:0] idx,
                              logic [nwc_pkg::CSR_DATA_W-1:0] data);
         unique case (idx)
            nwc_pkg::REG_FILTER_MODE:  mode = data[0];
            nwc_pkg::REG_WINDOW_ROWS:  win_rows = data[2:0];
            nwc_pkg::REG_WINDOW_COLS:  win_cols = data[2:0];
            nwc_pkg::REG_IMAGE_WIDTH:  img_width = data[11:0];
            nwc_pkg::REG_IMAGE_HEIGHT: img_height = data[12:0];
            default: ;
         endcase
      endfunction

      // advance the position, shift line stores and window, queue a result if interior
      function void note_request(logic [7:0] pix, logic frame_start);
         int w, h, u, v, r, c, cr, cc, acc, wsum, wt;
         int colv[5];
         filtered_pixel_type e;
         w = clip(img_width, nwc_pkg::MAX_WIDTH_DEF);
         h = clip(img_height, nwc_pkg::MAX_HEIGHT_DEF);
         if (mode) begin
            u = 5;
            v = 5;
         end else begin
            u = clip(win_rows, 5);
            v = clip(win_cols, 5);
         end
         if (frame_start) begin
            row_pos = 0;
            col_pos = 0;
         end
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         r = row_pos;
         c = col_pos;
         colv[4] = pix;
         for (int k = 0; k < 4; k++) colv[3-k] = line_mem[k*nwc_pkg::MAX_WIDTH_DEF + c];
         for (int k = 4; k > 1; k--)
            line_mem[(k-1)*nwc_pkg::MAX_WIDTH_DEF + c] =
               line_mem[(k-2)*nwc_pkg::MAX_WIDTH_DEF + c];
         line_mem[c] = pix;
         for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) window[i*5+j] = window[i*5+j+1];
            window[i*5+4] = colv[i];
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
         if (r + 1 < u || c + 1 < v) return;
         cr = r + 1 - u + u/2;
         cc = c + 1 - v + v/2;
         if (cr + u/2 > h - 1 || cc + v/2 > w - 1) return;
         acc = 0;
         wsum = 0;
         for (int i = 0; i < u; i++) begin
            for (int j = 0; j < v; j++) begin
               wt = mode ? int'(nwc_pkg::GAUSS_W[i*nwc_pkg::GAUSS_N + j]) : 1;
               acc += wt * window[(5-u+i)*5 + (5-v+j)];
               wsum += wt;
            end
         end
         e.row = nwc_pkg::ROW_OUT_W'(cr);
         e.col = nwc_pkg::COL_OUT_W'(cc);
         e.filtered = nwc_pkg::FILT_W'(acc / wsum);
         e.last = (cr == h - 1 - u/2) && (cc == w - 1 - v/2);
         pending.push_back(e);
      endfunction

      function void check_result(logic [nwc_pkg::ROW_OUT_W-1:0] row,
                                 logic [nwc_pkg::COL_OUT_W-1:0] col,
                                 logic [nwc_pkg::FILT_W-1:0] filt, logic last);
         filtered_pixel_type e;
         results_seen++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result row %0d col %0d filtered %0d last %0b",
                        row, col, filt, last);
            return;
         end
         e = pending.pop_front();
         if (row !== e.row || col !== e.col || filt !== e.filtered || last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp row %0d col %0d filt %0d last %0b, got %0d %0d %0d %0b",
                        e.row, e.col, e.filtered, e.last, row, col, filt, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                           csr_write_enable;
   logic [nwc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [nwc_pkg::CSR_DATA_W-1:0] csr_write_data;

   nwc_req_if req_bus();
   nwc_rsp_if rsp_bus();

   normalized_window_convolution_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   filter_scoreboard sb = new();
   bit  req_idle_on = 1;
   bit  rsp_idle_on = 1;
   bit  rsp_hold_request = 0;
   int  requests_sent = 0;
   int  settings_used = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 1500000);
      $display("FAILED: results differ");
      $finish;
   end

   // result side: random back-pressure plus one long hold-off counted here
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request && !hold_done) begin
            hold_left = 300;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = !rsp_idle_on || ($urandom_range(99) >= 24);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.center_row, rsp_bus.center_col, rsp_bus.filtered,
                         rsp_bus.last);
   end

   task automatic send_pixel(logic [7:0] pix, logic frame_start);
      while (req_idle_on && $urandom_range(99) < 24) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.pixel = pix;
      req_bus.frame_start = frame_start;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(pix, frame_start);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      int guard;
      req_bus.valid = 1'b0;
      guard = 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      // requests that make no result may still be in flight
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [nwc_pkg::CSR_IDX_W-1:0] idx, int data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = nwc_pkg::CSR_DATA_W'(data);
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_reg(idx, nwc_pkg::CSR_DATA_W'(data));
   endtask

   task automatic set_geometry(int mode, int rows, int cols, int width, int height);
      write_reg(nwc_pkg::REG_FILTER_MODE, mode);
      write_reg(nwc_pkg::REG_WINDOW_ROWS, rows);
      write_reg(nwc_pkg::REG_WINDOW_COLS, cols);
      write_reg(nwc_pkg::REG_IMAGE_WIDTH, width);
      write_reg(nwc_pkg::REG_IMAGE_HEIGHT, height);
      settings_used++;
   endtask

   // frame_start on the first request; the rest may wrap or restart at random
   task automatic run_frames(int count, bit restarts);
      logic fs;
      for (int n = 0; n < count; n++) begin
         fs = (n == 0) || (restarts && $urandom_range(99) < 2);
         send_pixel(8'($urandom_range(255)), fs);
      end
   endtask

   initial begin
      int w, h, n;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      req_bus.frame_start = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: 3x3 mean on a 5x4 image, extreme and mid-scale pixel values
      set_geometry(0, 3, 3, 5, 4);
      for (int k = 0; k < 20; k++)
         send_pixel((k % 3 == 0) ? 8'd255 : ((k % 3 == 1) ? 8'd0 : 8'd128), k == 0);
      wait_idle();

      // 1x1 window on the widest image, oversize register values saturate
      set_geometry(0, 1, 1, 4095, 8191);
      run_frames(30, 0);
      wait_idle();
      // zero size image and window act as 1x1, so every pixel is an interior centre
      set_geometry(0, 0, 0, 0, 0);
      run_frames(12, 0);
      wait_idle();
      // Gaussian, two frames back to back without a second frame start
      set_geometry(1, 0, 7, 6, 6);
      run_frames(72, 0);
      wait_idle();
      // even and oversize windows
      set_geometry(0, 2, 7, 7, 6);
      run_frames(42, 0);
      wait_idle();
      set_geometry(0, 6, 4, 8, 7);
      run_frames(56, 0);
      wait_idle();

      // result side held off while requests keep coming, no random idling
      req_idle_on = 0;
      rsp_idle_on = 0;
      set_geometry(0, 1, 1, 10, 10);
      rsp_hold_request = 1'b1;
      run_frames(60, 0);
      wait_idle();
      req_idle_on = 1;
      rsp_idle_on = 1;

      while (requests_sent < 900) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         if (w > 40 || w == 0) h = $urandom_range(0, 6);
         set_geometry($urandom_range(1), $urandom_range(7), $urandom_range(7), w, h);
         n = (w >= 1 && w <= 12) ? w * h * $urandom_range(1, 2) + $urandom_range(5)
                                 : $urandom_range(10, 60);
         run_frames(n, 1);
         wait_idle();
      end

      wait_idle();
      $display("Ran %0d pixel requests under %0d register settings, %0d filtered results",
               requests_sent, settings_used, sb.results_seen);
      if (sb.pending.size() != 0)
         $display("%0d expected results never arrived", sb.pending.size());
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/nwc_pkg.sv
sv/nwc_req_if.sv
sv/nwc_rsp_if.sv
sv/nwc_front.sv
sv/nwc_queue.sv
sv/nwc_back.sv
sv/normalized_window_convolution_unit.sv
verif/normalized_window_convolution_unit_tb.sv
